[rtl/vwad_pkg.sv]
// Shared types, constants and step table for the variable-width ADPCM decoder.
package vwad_pkg;

	localparam int PredW = 12;
	localparam int SidxW = 7;
	localparam int StepW = 14;
	localparam int MagW  = 15;
	localparam int PosW  = 4;

	localparam logic signed [PredW-1:0] PredMin   = -12'sd2048;
	localparam logic signed [PredW-1:0] PredMax   = 12'sd2047;
	localparam logic [SidxW-1:0]        SidxStart = 7'd40;
	localparam logic [SidxW-1:0]        SidxMax   = 7'd79;
	localparam logic [SidxW-1:0]        WideMinSidx = 7'd18;
	localparam logic [PosW-1:0]         WideMaxPos  = 4'd4;

	localparam logic signed [4:0] AdjDown = -5'sd1;
	localparam logic signed [4:0] AdjUp   = 5'sd2;

	localparam logic signed [4:0] AdjWide [16] = '{
		-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8,
		-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
	};

	typedef struct packed {
		logic signed [PredW-1:0] pred;
		logic [SidxW-1:0]        sidx;
		logic                    wide;
	} vwad_step_res_t;

	function automatic logic [StepW-1:0] step_size(input logic [SidxW-1:0] idx);
		logic [StepW-1:0] s;
		case (idx)
			7'd0:  s = 14'd7;     7'd1:  s = 14'd8;     7'd2:  s = 14'd9;
			7'd3:  s = 14'd10;    7'd4:  s = 14'd11;    7'd5:  s = 14'd12;
			7'd6:  s = 14'd13;    7'd7:  s = 14'd14;    7'd8:  s = 14'd16;
			7'd9:  s = 14'd17;    7'd10: s = 14'd19;    7'd11: s = 14'd21;
			7'd12: s = 14'd23;    7'd13: s = 14'd25;    7'd14: s = 14'd28;
			7'd15: s = 14'd31;    7'd16: s = 14'd34;    7'd17: s = 14'd37;
			7'd18: s = 14'd41;    7'd19: s = 14'd45;    7'd20: s = 14'd50;
			7'd21: s = 14'd55;    7'd22: s = 14'd60;    7'd23: s = 14'd66;
			7'd24: s = 14'd73;    7'd25: s = 14'd80;    7'd26: s = 14'd88;
			7'd27: s = 14'd97;    7'd28: s = 14'd107;   7'd29: s = 14'd118;
			7'd30: s = 14'd130;   7'd31: s = 14'd143;   7'd32: s = 14'd157;
			7'd33: s = 14'd173;   7'd34: s = 14'd190;   7'd35: s = 14'd209;
			7'd36: s = 14'd230;   7'd37: s = 14'd253;   7'd38: s = 14'd279;
			7'd39: s = 14'd307;   7'd40: s = 14'd337;   7'd41: s = 14'd371;
			7'd42: s = 14'd408;   7'd43: s = 14'd449;   7'd44: s = 14'd494;
			7'd45: s = 14'd544;   7'd46: s = 14'd598;   7'd47: s = 14'd658;
			7'd48: s = 14'd724;   7'd49: s = 14'd796;   7'd50: s = 14'd876;
			7'd51: s = 14'd963;   7'd52: s = 14'd1060;  7'd53: s = 14'd1166;
			7'd54: s = 14'd1282;  7'd55: s = 14'd1411;  7'd56: s = 14'd1552;
			7'd57: s = 14'd1707;  7'd58: s = 14'd1878;  7'd59: s = 14'd2066;
			7'd60: s = 14'd2272;  7'd61: s = 14'd2499;  7'd62: s = 14'd2749;
			7'd63: s = 14'd3024;  7'd64: s = 14'd3327;  7'd65: s = 14'd3660;
			7'd66: s = 14'd4026;  7'd67: s = 14'd4428;  7'd68: s = 14'd4871;
			7'd69: s = 14'd5358;  7'd70: s = 14'd5894;  7'd71: s = 14'd6484;
			7'd72: s = 14'd7132;  7'd73: s = 14'd7845;  7'd74: s = 14'd8630;
			7'd75: s = 14'd9493;  7'd76: s = 14'd10442; 7'd77: s = 14'd11487;
			7'd78: s = 14'd12635; 7'd79: s = 14'd13899;
			default: s = 14'd13899;
		endcase
		return s;
	endfunction

endpackage

[rtl/vwad_if.sv]
// Valid/ready channel interfaces for compressed bytes and decoded samples.
interface vwad_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       first_byte;
	logic       last_byte;

	modport source(output valid, output code_byte, output first_byte, output last_byte,
		input ready);
	modport sink(input valid, input code_byte, input first_byte, input last_byte,
		output ready);
endinterface

interface vwad_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pcm_sample;
	logic               last_of_byte;
	logic               track_end;

	modport source(output valid, output pcm_sample, output last_of_byte, output track_end,
		input ready);
	modport sink(input valid, input pcm_sample, input last_of_byte, input track_end,
		output ready);
endinterface

[rtl/vwad_code_unit.sv]
// Shared per-code unit: step lookup, difference, predictor and step index update.
module vwad_code_unit (
	input  logic signed [vwad_pkg::PredW-1:0] pred,
	input  logic [vwad_pkg::SidxW-1:0]        sidx,
	input  logic [3:0]                        bits,
	input  logic [vwad_pkg::PosW-1:0]         pos,
	output vwad_pkg::vwad_step_res_t          res
);

	logic [vwad_pkg::StepW-1:0] step;
	logic                       wide;
	logic                       neg;
	logic [vwad_pkg::MagW-1:0]  mag;
	logic signed [16:0]         sum;
	logic signed [4:0]          adj;
	logic signed [7:0]          sidx_sum;

	always_comb begin
		step = vwad_pkg::step_size(sidx);
		wide = (sidx >= vwad_pkg::WideMinSidx) && (pos <= vwad_pkg::WideMaxPos);
		mag  = {4'd0, step[13:3]};
		if (wide) begin
			if (bits[0]) mag = mag + {3'd0, step[13:2]};
			if (bits[1]) mag = mag + {2'd0, step[13:1]};
			if (bits[2]) mag = mag + {1'b0, step};
			neg = bits[3];
			adj = vwad_pkg::AdjWide[bits];
		end else begin
			if (bits[0]) mag = mag + {1'b0, step};
			neg = bits[1];
			adj = bits[0] ? vwad_pkg::AdjUp : vwad_pkg::AdjDown;
		end

		sum = neg ? ({{5{pred[11]}}, pred} - $signed({2'b00, mag}))
			: ({{5{pred[11]}}, pred} + $signed({2'b00, mag}));
		if (sum < $signed({{5{vwad_pkg::PredMin[11]}}, vwad_pkg::PredMin}))
			res.pred = vwad_pkg::PredMin;
		else if (sum > $signed({5'd0, vwad_pkg::PredMax}))
			res.pred = vwad_pkg::PredMax;
		else
			res.pred = sum[11:0];

		sidx_sum = $signed({1'b0, sidx}) + {{3{adj[4]}}, adj};
		if (sidx_sum < 8'sd0)
			res.sidx = '0;
		else if (sidx_sum > $signed({1'b0, vwad_pkg::SidxMax}))
			res.sidx = vwad_pkg::SidxMax;
		else
			res.sidx = sidx_sum[6:0];

		res.wide = wide;
	end

endmodule

[rtl/variable_width_adpcm_decoder_core.sv]
// Top level: byte sequencer around the shared code unit, with a sample output register.
//
//   channel  dir  payload                                   transaction
//   codes    in   code_byte[8], first_byte, last_byte       one compressed byte
//   samples  out  pcm_sample[16], last_of_byte, track_end   one decoded sample
//
// One byte holds 2 to 4 codes, decoded one code per cycle through the code unit while
// samples does not stall; codes is not ready while a byte is being decoded.
// Reset gives predictor 0 and step index 40.
// A stalled samples transaction holds the decoder in place until it is taken.
module variable_width_adpcm_decoder_core (
	input  logic         clk,
	input  logic         arst_n,
	vwad_in_if.sink      codes,
	vwad_out_if.source   samples
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_DECODE = 1'b1;

	logic                              state_q;
	logic signed [vwad_pkg::PredW-1:0] pred_q;
	logic [vwad_pkg::SidxW-1:0]        sidx_q;
	logic [7:0]                        bits_q;
	logic [vwad_pkg::PosW-1:0]         pos_q;
	logic                              last_q;
	logic                              out_valid_q;
	logic signed [15:0]                pcm_q;
	logic                              lob_q;
	logic                              te_q;

	vwad_pkg::vwad_step_res_t          res;
	logic                              step_go;
	logic [vwad_pkg::PosW-1:0]         pos_nxt;

	vwad_code_unit u_code (
		.pred (pred_q),
		.sidx (sidx_q),
		.bits (bits_q[3:0]),
		.pos  (pos_q),
		.res  (res)
	);

	assign codes.ready = (state_q == ST_IDLE);
	assign step_go     = (state_q == ST_DECODE) && (!out_valid_q || samples.ready);
	assign pos_nxt     = pos_q + (res.wide ? 4'd4 : 4'd2);

	assign samples.valid        = out_valid_q;
	assign samples.pcm_sample   = pcm_q;
	assign samples.last_of_byte = lob_q;
	assign samples.track_end    = te_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pred_q      <= '0;
			sidx_q      <= vwad_pkg::SidxStart;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (codes.valid && codes.ready) begin
				if (codes.first_byte) begin
					pred_q <= '0;
					sidx_q <= vwad_pkg::SidxStart;
				end
				pos_q   <= '0;
				state_q <= ST_DECODE;
			end
			if (step_go) begin
				pred_q      <= res.pred;
				sidx_q      <= res.sidx;
				pos_q       <= pos_nxt;
				out_valid_q <= 1'b1;
				if (pos_nxt[3]) state_q <= ST_IDLE;
			end else if (out_valid_q && samples.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (codes.valid && codes.ready) begin
			bits_q <= codes.code_byte;
			last_q <= codes.last_byte;
		end
		if (step_go) begin
			bits_q <= res.wide ? {4'd0, bits_q[7:4]} : {2'd0, bits_q[7:2]};
			pcm_q  <= {res.pred, 4'd0};
			lob_q  <= pos_nxt[3];
			te_q   <= pos_nxt[3] && last_q;
		end
	end

endmodule
